### sv/mtp_pkg.sv
// Shared constants, codes and types of the MIDI track event parser.
`default_nettype none
package mtp_pkg;

    // Field and state widths.
    localparam int TIME_BITS  = 48;
    localparam int TICK_BITS  = 32;
    localparam int VLQ_BITS   = 32;
    localparam int TEMPO_BITS = 24;
    localparam int DVSR_BITS  = 16;

    // Width of the tick-by-tempo product and of the divider dividend.
    localparam int DIVW      = TICK_BITS + TEMPO_BITS;
    // Width of the tempo time plus the scaled tick difference.
    localparam int SUMW      = ((TIME_BITS > DIVW) ? TIME_BITS : DIVW) + 1;
    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS = DIVW / 2;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    // Status and meta codes.
    localparam logic [7:0] BYTE_META   = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX  = 8'hF0;
    localparam logic [7:0] BYTE_ESCAPE = 8'hF7;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] ONE_DATA_LO = 8'hC0;
    localparam logic [7:0] ONE_DATA_HI = 8'hDF;

    localparam logic [DVSR_BITS-1:0]  MS_PER_SEC = 16'd1000;
    localparam logic [TEMPO_BITS-1:0] MS_SCALE   = 24'd1000;
    localparam logic [TIME_BITS-1:0]  TIME_MAX   = '1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_DIVISION = 1'b0;
    localparam logic REG_FORMAT   = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHANNEL    = 2'd0,
        KIND_END        = 2'd1,
        KIND_BAD_STATUS = 2'd2,
        KIND_TRUNCATED  = 2'd3
    } t_kind;

    typedef enum logic [7:0] {
        PH_DELTA     = 8'b0000_0001,
        PH_EVENT     = 8'b0000_0010,
        PH_DATA1     = 8'b0000_0100,
        PH_DATA2     = 8'b0000_1000,
        PH_META_TYPE = 8'b0001_0000,
        PH_META_LEN  = 8'b0010_0000,
        PH_SYSEX_LEN = 8'b0100_0000,
        PH_SKIP      = 8'b1000_0000
    } t_phase;

    // Commands from the controller to the datapath and divider.
    typedef struct packed {
        logic step;
        logic mul;
        logic div_start;
        logic div_second;
        logic fin;
        logic load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_mul;
        logic tempo_mode;
        logic res_pend;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### sv/mtp_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
`default_nettype none
module mtp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [mtp_pkg::DIVW-1:0]       i_dividend,
    input  wire logic [mtp_pkg::DVSR_BITS-1:0]  i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [mtp_pkg::DIVW-1:0]            o_quotient
);

    logic [mtp_pkg::DIVW-1:0]      r_acc, n_acc;
    logic [mtp_pkg::DVSR_BITS-1:0] r_rem, n_rem;
    logic [mtp_pkg::DVSR_BITS-1:0] r_dvsr;
    logic [mtp_pkg::CNT_BITS-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // Two restoring steps; the remainder always stays below the divisor.
    always_comb begin
        logic [mtp_pkg::DVSR_BITS:0] trial;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_acc[mtp_pkg::DIVW-1]};
            n_acc = {n_acc[mtp_pkg::DIVW-2:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                trial    = trial - {1'b0, r_dvsr};
                n_acc[0] = 1'b1;
            end
            n_rem = trial[mtp_pkg::DVSR_BITS-1:0];
        end
    end

    // Control of the iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mtp_pkg::CNT_BITS'(mtp_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mtp_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule
`default_nettype wire

### sv/mtp_ctrl.sv
// Controller state machine of the MIDI track event parser.
`default_nettype none
module mtp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire mtp_pkg::t_status i_status,
    input  wire logic             i_div_done,
    output mtp_pkg::t_cmd         o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_CHECK = 9'b0_0000_0010,
        S_MUL   = 9'b0_0000_0100,
        S_DIVA  = 9'b0_0000_1000,
        S_WAITA = 9'b0_0001_0000,
        S_DIVB  = 9'b0_0010_0000,
        S_WAITB = 9'b0_0100_0000,
        S_FIN   = 9'b0_1000_0000,
        S_OUT   = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.need_mul ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAITA;
            end
            S_WAITA: begin
                if (i_div_done) begin
                    n_state = i_status.tempo_mode ? S_DIVB : S_FIN;
                end
            end
            S_DIVB: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_second = 1'b1;
                n_state          = S_WAITB;
            end
            S_WAITB: begin
                if (i_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!i_status.res_pend) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### sv/mtp_dp.sv
// Datapath of the MIDI track event parser: parse state, timing and result word.
`default_nettype none
module mtp_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mtp_pkg::t_cmd                  i_cmd,
    output mtp_pkg::t_status                    o_status,
    // Input word
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_first_of_track,
    input  wire logic                           i_last_of_track,
    input  wire logic                           i_first_of_file,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    // Divider
    output logic [mtp_pkg::DIVW-1:0]            o_div_dividend,
    output logic [mtp_pkg::DVSR_BITS-1:0]       o_div_divisor,
    input  wire logic [mtp_pkg::DIVW-1:0]       i_div_quotient,
    // Output word
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_result_kind,
    output logic [7:0]                          o_status_value,
    output logic [6:0]                          o_first_data,
    output logic [6:0]                          o_second_data,
    output logic [3:0]                          o_channel_number,
    output logic [mtp_pkg::TIME_BITS-1:0]       o_time_ms
);

    localparam int TB = mtp_pkg::TIME_BITS;
    localparam int KB = mtp_pkg::TICK_BITS;
    localparam int VB = mtp_pkg::VLQ_BITS;
    localparam int PB = mtp_pkg::TEMPO_BITS;

    // Configuration registers.
    logic [15:0] r_division;
    logic [1:0]  r_format;

    // Parse state.
    mtp_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_running, n_running;
    logic [VB-1:0] r_vlq, n_vlq;
    logic [KB-1:0] r_tick, n_tick;
    logic [TB-1:0] r_cur_time, n_cur_time;
    logic          r_tempo_valid, n_tempo_valid;
    logic [PB-1:0] r_tempo, n_tempo;
    logic [KB-1:0] r_tempo_tick, n_tempo_tick;
    logic [TB-1:0] r_tempo_time, n_tempo_time;
    logic [VB-1:0] r_skip, n_skip;
    logic [7:0]    r_pend_st, n_pend_st;
    logic [6:0]    r_pend_d1, n_pend_d1;
    logic [7:0]    r_meta_kind, n_meta_kind;
    logic [PB-1:0] r_meta_bytes, n_meta_bytes;
    logic [1:0]    r_meta_cnt, n_meta_cnt;
    logic          r_lock, n_lock;

    // Pending result and time update request.
    logic          r_rp, n_rp;
    logic [1:0]    r_rk, n_rk;
    logic [7:0]    r_rst, n_rst;
    logic [6:0]    r_rd1, n_rd1;
    logic [6:0]    r_rd2, n_rd2;
    logic [3:0]    r_rch, n_rch;
    logic          r_upd_mul, n_upd_mul;
    logic          r_upd_tempo, n_upd_tempo;

    // Time computation.
    logic [mtp_pkg::DIVW-1:0] r_prod;
    logic [KB-1:0]            w_dt;
    logic [KB-1:0]            w_mul_a;
    logic [PB-1:0]            w_mul_b;
    logic [8:0]               w_fps;
    logic [16:0]              w_frame_rate;
    logic [mtp_pkg::SUMW-1:0] w_sum;

    // Output register.
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_st;
    logic [6:0]    r_out_d1;
    logic [6:0]    r_out_d2;
    logic [3:0]    r_out_ch;
    logic [TB-1:0] r_out_time;

    logic w_cfg_wr;

    // Configuration writes and reads.
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_division <= 16'd96;
            r_format   <= 2'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == mtp_pkg::REG_DIVISION) begin
                r_division <= pwdata[15:0];
            end else begin
                r_format <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == mtp_pkg::REG_DIVISION) begin
            prdata = {16'd0, r_division};
        end else begin
            prdata = {30'd0, r_format};
        end
    end

    // One parse step per accepted word.
    always_comb begin
        logic [7:0]    b;
        logic [VB-1:0] vlq_new;
        logic          bad;
        logic          chan_go;
        logic [7:0]    chan_st;
        logic [6:0]    chan_d1;
        logic [6:0]    chan_d2;
        logic          fin_go;

        n_phase       = r_phase;
        n_running     = r_running;
        n_vlq         = r_vlq;
        n_tick        = r_tick;
        n_cur_time    = r_cur_time;
        n_tempo_valid = r_tempo_valid;
        n_tempo       = r_tempo;
        n_tempo_tick  = r_tempo_tick;
        n_tempo_time  = r_tempo_time;
        n_skip        = r_skip;
        n_pend_st     = r_pend_st;
        n_pend_d1     = r_pend_d1;
        n_meta_kind   = r_meta_kind;
        n_meta_bytes  = r_meta_bytes;
        n_meta_cnt    = r_meta_cnt;
        n_lock        = r_lock;
        n_rp          = r_rp;
        n_rk          = r_rk;
        n_rst         = r_rst;
        n_rd1         = r_rd1;
        n_rd2         = r_rd2;
        n_rch         = r_rch;
        n_upd_mul     = r_upd_mul;
        n_upd_tempo   = r_upd_tempo;

        b       = i_data_byte;
        vlq_new = {r_vlq[VB-8:0], b[6:0]};
        bad     = 1'b0;
        chan_go = 1'b0;
        chan_st = '0;
        chan_d1 = '0;
        chan_d2 = '0;
        fin_go  = 1'b0;

        if (i_cmd.step) begin
            n_rp      = 1'b0;
            n_rk      = mtp_pkg::KIND_CHANNEL;
            n_rst     = '0;
            n_rd1     = '0;
            n_rd2     = '0;
            n_rch     = '0;
            n_upd_mul = 1'b0;

            // Start of file, or of a track while unlocked, clears the track and maybe the tempo record.
            if (i_first_of_file || (i_first_of_track && !r_lock)) begin
                n_phase    = mtp_pkg::PH_DELTA;
                n_running  = '0;
                n_vlq      = '0;
                n_tick     = '0;
                n_cur_time = '0;
                n_skip     = '0;
                n_pend_st  = '0;
                n_pend_d1  = '0;
                n_meta_kind  = '0;
                n_meta_bytes = '0;
                n_meta_cnt   = '0;
                if (i_first_of_file || r_format[1]) begin
                    n_tempo_valid = 1'b0;
                    n_tempo       = '0;
                    n_tempo_tick  = '0;
                    n_tempo_time  = '0;
                end
                if (i_first_of_file) begin
                    n_lock = 1'b0;
                end
            end
            vlq_new = {n_vlq[VB-8:0], b[6:0]};

            if (!n_lock) begin
                unique case (n_phase)
                    mtp_pkg::PH_DELTA: begin
                        n_vlq = vlq_new;
                        if (!b[7]) begin
                            n_tick  = n_tick + vlq_new[KB-1:0];
                            n_vlq   = '0;
                            n_phase = mtp_pkg::PH_EVENT;
                            if (r_division[15]) begin
                                if (r_division[7:0] != 8'd0) begin
                                    n_upd_mul   = 1'b1;
                                    n_upd_tempo = 1'b0;
                                end
                            end else if (n_tempo_valid) begin
                                if (r_division != 16'd0) begin
                                    n_upd_mul   = 1'b1;
                                    n_upd_tempo = 1'b1;
                                end else begin
                                    n_cur_time = n_tempo_time;
                                end
                            end
                        end
                    end
                    mtp_pkg::PH_EVENT: begin
                        if (b == mtp_pkg::BYTE_META) begin
                            n_running = '0;
                            n_phase   = mtp_pkg::PH_META_TYPE;
                        end else if (b == mtp_pkg::BYTE_SYSEX ||
                                     b == mtp_pkg::BYTE_ESCAPE) begin
                            n_running    = '0;
                            n_meta_kind  = '0;
                            n_meta_bytes = '0;
                            n_meta_cnt   = '0;
                            n_phase      = mtp_pkg::PH_SYSEX_LEN;
                        end else if (b > mtp_pkg::BYTE_SYSEX) begin
                            bad    = 1'b1;
                            n_lock = 1'b1;
                            n_rp   = 1'b1;
                            n_rk   = mtp_pkg::KIND_BAD_STATUS;
                            n_rst  = b;
                        end else if (b[7]) begin
                            n_pend_st = b;
                            n_pend_d1 = '0;
                            n_phase   = mtp_pkg::PH_DATA1;
                        end else if (n_running >= mtp_pkg::ONE_DATA_LO &&
                                     n_running <= mtp_pkg::ONE_DATA_HI) begin
                            chan_go = 1'b1;
                            chan_st = n_running;
                            chan_d1 = b[6:0];
                        end else begin
                            n_pend_st = n_running;
                            n_pend_d1 = b[6:0];
                            n_phase   = mtp_pkg::PH_DATA2;
                        end
                    end
                    mtp_pkg::PH_DATA1: begin
                        if (n_pend_st >= mtp_pkg::ONE_DATA_LO &&
                            n_pend_st <= mtp_pkg::ONE_DATA_HI) begin
                            chan_go = 1'b1;
                            chan_st = n_pend_st;
                            chan_d1 = b[6:0];
                        end else begin
                            n_pend_d1 = b[6:0];
                            n_phase   = mtp_pkg::PH_DATA2;
                        end
                    end
                    mtp_pkg::PH_DATA2: begin
                        chan_go = 1'b1;
                        chan_st = n_pend_st;
                        chan_d1 = n_pend_d1;
                        chan_d2 = b[6:0];
                    end
                    mtp_pkg::PH_META_TYPE: begin
                        n_meta_kind  = b;
                        n_meta_bytes = '0;
                        n_meta_cnt   = '0;
                        n_vlq        = '0;
                        n_phase      = mtp_pkg::PH_META_LEN;
                    end
                    mtp_pkg::PH_META_LEN, mtp_pkg::PH_SYSEX_LEN: begin
                        n_vlq = vlq_new;
                        if (!b[7]) begin
                            n_skip = vlq_new;
                            n_vlq  = '0;
                            if (vlq_new == '0) begin
                                fin_go = 1'b1;
                            end else begin
                                n_phase = mtp_pkg::PH_SKIP;
                            end
                        end
                    end
                    mtp_pkg::PH_SKIP: begin
                        if (n_meta_cnt != 2'd3) begin
                            n_meta_bytes = {n_meta_bytes[PB-9:0], b};
                            n_meta_cnt   = n_meta_cnt + 2'd1;
                        end
                        n_skip = n_skip - {{(VB-1){1'b0}}, 1'b1};
                        if (n_skip == '0) begin
                            fin_go = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = mtp_pkg::PH_DELTA;
                    end
                endcase

                // A complete channel message; all-zero words are dropped.
                if (chan_go) begin
                    n_phase   = mtp_pkg::PH_DELTA;
                    n_running = chan_st;
                    if (chan_st != 8'd0 || chan_d1 != 7'd0 || chan_d2 != 7'd0) begin
                        n_rp  = 1'b1;
                        n_rk  = mtp_pkg::KIND_CHANNEL;
                        n_rst = chan_st;
                        n_rd1 = chan_d1;
                        n_rd2 = chan_d2;
                        n_rch = chan_st[3:0];
                    end
                end

                // End of a meta or sysex payload.
                if (fin_go) begin
                    n_phase = mtp_pkg::PH_DELTA;
                    if (n_meta_kind == mtp_pkg::META_TEMPO && n_meta_cnt == 2'd3) begin
                        n_tempo       = n_meta_bytes;
                        n_tempo_tick  = n_tick;
                        n_tempo_time  = n_cur_time;
                        n_tempo_valid = 1'b1;
                    end else if (n_meta_kind == mtp_pkg::META_EOT) begin
                        n_rp = 1'b1;
                        n_rk = mtp_pkg::KIND_END;
                    end
                    n_meta_kind  = '0;
                    n_meta_bytes = '0;
                    n_meta_cnt   = '0;
                end

                // A track that ends inside an event is truncated.
                if (!bad && i_last_of_track &&
                    (n_phase != mtp_pkg::PH_DELTA || n_vlq != '0 ||
                     (b[7] && !n_rp))) begin
                    n_lock = 1'b1;
                    n_rp   = 1'b1;
                    n_rk   = mtp_pkg::KIND_TRUNCATED;
                    n_rst  = '0;
                    n_rd1  = '0;
                    n_rd2  = '0;
                    n_rch  = '0;
                end
            end
        end

        // Final timestamp after the divider passes, saturated.
        if (i_cmd.fin) begin
            if (r_upd_tempo) begin
                w_sum = mtp_pkg::SUMW'(r_tempo_time) + mtp_pkg::SUMW'(i_div_quotient);
            end else begin
                w_sum = mtp_pkg::SUMW'(i_div_quotient);
            end
            if (w_sum > mtp_pkg::SUMW'(mtp_pkg::TIME_MAX)) begin
                n_cur_time = mtp_pkg::TIME_MAX;
            end else begin
                n_cur_time = w_sum[TB-1:0];
            end
        end else begin
            w_sum = '0;
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mtp_pkg::PH_DELTA;
            r_running     <= '0;
            r_vlq         <= '0;
            r_tick        <= '0;
            r_cur_time    <= '0;
            r_tempo_valid <= 1'b0;
            r_tempo       <= '0;
            r_tempo_tick  <= '0;
            r_tempo_time  <= '0;
            r_skip        <= '0;
            r_pend_st     <= '0;
            r_pend_d1     <= '0;
            r_meta_kind   <= '0;
            r_meta_bytes  <= '0;
            r_meta_cnt    <= '0;
            r_lock        <= 1'b0;
            r_rp          <= 1'b0;
            r_upd_mul     <= 1'b0;
            r_upd_tempo   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_running     <= n_running;
            r_vlq         <= n_vlq;
            r_tick        <= n_tick;
            r_cur_time    <= n_cur_time;
            r_tempo_valid <= n_tempo_valid;
            r_tempo       <= n_tempo;
            r_tempo_tick  <= n_tempo_tick;
            r_tempo_time  <= n_tempo_time;
            r_skip        <= n_skip;
            r_pend_st     <= n_pend_st;
            r_pend_d1     <= n_pend_d1;
            r_meta_kind   <= n_meta_kind;
            r_meta_bytes  <= n_meta_bytes;
            r_meta_cnt    <= n_meta_cnt;
            r_lock        <= n_lock;
            r_rp          <= n_rp;
            r_upd_mul     <= n_upd_mul;
            r_upd_tempo   <= n_upd_tempo;
        end
    end

    // Pending result fields.
    always_ff @(posedge i_clk) begin
        r_rk  <= n_rk;
        r_rst <= n_rst;
        r_rd1 <= n_rd1;
        r_rd2 <= n_rd2;
        r_rch <= n_rch;
    end

    // Multiplier operands: ticks times 1000, or tick difference times tempo.
    assign w_dt    = (r_tick >= r_tempo_tick) ? (r_tick - r_tempo_tick) : '0;
    assign w_mul_a = r_upd_tempo ? w_dt : r_tick;
    assign w_mul_b = r_upd_tempo ? r_tempo : mtp_pkg::MS_SCALE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= mtp_pkg::DIVW'(w_mul_a) * mtp_pkg::DIVW'(w_mul_b);
        end
    end

    // Divider operands: frames per second times ticks per frame, the division
    // word, or 1000 for the second tempo pass.
    assign w_fps        = 9'd256 - {1'b0, r_division[15:8]};
    assign w_frame_rate = w_fps * {1'b0, r_division[7:0]};

    always_comb begin
        if (i_cmd.div_second) begin
            o_div_dividend = i_div_quotient;
            o_div_divisor  = mtp_pkg::MS_PER_SEC;
        end else begin
            o_div_dividend = r_prod;
            o_div_divisor  = r_upd_tempo ? r_division : w_frame_rate[15:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_kind <= r_rk;
            r_out_st   <= r_rst;
            r_out_d1   <= r_rd1;
            r_out_d2   <= r_rd2;
            r_out_ch   <= r_rch;
            r_out_time <= r_cur_time;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_status_value   = r_out_st;
    assign o_first_data     = r_out_d1;
    assign o_second_data    = r_out_d2;
    assign o_channel_number = r_out_ch;
    assign o_time_ms        = r_out_time;

    assign o_status.need_mul   = r_upd_mul;
    assign o_status.tempo_mode = r_upd_tempo;
    assign o_status.res_pend   = r_rp;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

### sv/midi_track_event_parser_unit.sv
// Top level of the MIDI track event parser.
//
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   data byte, track and file marks
//  out       output     o_out_valid / i_out_ready kind, status, data, channel, time
//  config    input      APB psel/penable/pwrite   division (0x0), file format (0x4)
//
// A word that completes no delta time passes the check and output states
// only. A word that completes a delta time also passes the multiply and one
// pass of the two-bit-per-cycle divider under SMPTE timing, or two passes
// under tempo timing. Reset is synchronous and active low; it clears the parse
// state and the tempo record. A result waits in the output register while the
// next word is taken; only loading a new result stalls on i_out_ready.
`default_nettype none
module midi_track_event_parser_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_first_of_track,
    input  wire logic                          i_last_of_track,
    input  wire logic                          i_first_of_file,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_result_kind,
    output logic [7:0]                         o_status_value,
    output logic [6:0]                         o_first_data,
    output logic [6:0]                         o_second_data,
    output logic [3:0]                         o_channel_number,
    output logic [mtp_pkg::TIME_BITS-1:0]      o_time_ms,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    mtp_pkg::t_cmd                  w_cmd;
    mtp_pkg::t_status               w_status;
    logic [mtp_pkg::DIVW-1:0]       w_div_dividend;
    logic [mtp_pkg::DVSR_BITS-1:0]  w_div_divisor;
    logic [mtp_pkg::DIVW-1:0]       w_div_quotient;
    logic                           w_div_busy;
    logic                           w_div_done;

    assign pready = 1'b1;

    mtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .i_div_done (w_div_done),
        .o_cmd      (w_cmd)
    );

    mtp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_data_byte      (i_data_byte),
        .i_first_of_track (i_first_of_track),
        .i_last_of_track  (i_last_of_track),
        .i_first_of_file  (i_first_of_file),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .o_div_dividend   (w_div_dividend),
        .o_div_divisor    (w_div_divisor),
        .i_div_quotient   (w_div_quotient),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_status_value   (o_status_value),
        .o_first_data     (o_first_data),
        .o_second_data    (o_second_data),
        .o_channel_number (o_channel_number),
        .o_time_ms        (o_time_ms)
    );

    mtp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cmd.div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    // The parser only takes a word when no division is in flight.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_busy)
        else $error("input ready while divider busy");

    // An accepted word always occupies the controller for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted word");

    // A result is loaded only into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_out_valid || i_out_ready))
        else $error("output word overwritten");

    // The divider is never restarted mid-division.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire
